@@ rtl/f64_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f64_pkg
// Shared types, constants and arithmetic helpers for the fletcher-64 unit.
// ----------------------------------------------------------------------------
package f64_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned SUM2_W  = 2 * WORD_W;

   localparam logic [WORD_W-1:0]  MOD_VALUE = {WORD_W{1'b1}};

   localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;

   typedef struct packed {
      logic [WORD_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic               last;
   } beat_type;

   // partial words pack the first byte most significant, full words are taken as is
   function automatic logic [WORD_W-1:0] form_addend(input logic [WORD_W-1:0] bytes,
                                                      input logic [COUNT_W-1:0] count);
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [WORD_W-1:0] addend;
      b0 = bytes[BYTE_W-1:0];
      b1 = bytes[2*BYTE_W-1:BYTE_W];
      b2 = bytes[3*BYTE_W-1:2*BYTE_W];
      case (count)
         COUNT_NONE:  addend = '0;
         COUNT_ONE:   addend = {{(WORD_W-BYTE_W){1'b0}}, b0};
         COUNT_TWO:   addend = {{(WORD_W-2*BYTE_W){1'b0}}, b0, b1};
         COUNT_THREE: addend = {{(WORD_W-3*BYTE_W){1'b0}}, b0, b1, b2};
         default:     addend = bytes;
      endcase
      return addend;
   endfunction

   // addition modulo 2^32-1 by end-around carry, all ones folded to zero
   function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [WORD_W:0]   total;
      logic [WORD_W-1:0] folded;
      total  = {1'b0, a} + {1'b0, b};
      folded = total[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, total[WORD_W]};
      return (folded == MOD_VALUE) ? '0 : folded;
   endfunction

endpackage

@@ rtl/f64_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f64_accum
// Holds the two running sums and works out the checksum for the current beat.
// ----------------------------------------------------------------------------
module f64_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  f64_pkg::beat_type             beat,
   output logic [f64_pkg::SUM2_W-1:0]    checksum
);
   import f64_pkg::*;

   logic [WORD_W-1:0] sum_low_ff;
   logic [WORD_W-1:0] sum_high_ff;
   logic [WORD_W-1:0] sum_low_in;
   logic [WORD_W-1:0] sum_high_in;
   logic [WORD_W-1:0] low_step;
   logic [WORD_W-1:0] high_step;
   logic              has_bytes;

   assign has_bytes = (beat.count != COUNT_NONE);
   assign low_step  = mod_add(sum_low_ff, form_addend(beat.data, beat.count));
   // second sum takes the freshly updated first sum
   assign high_step = mod_add(sum_high_ff, low_step);

   always_comb begin
      if (has_bytes) begin
         checksum = {high_step, low_step};
      end else begin
         checksum = {sum_high_ff, sum_low_ff};
      end
   end

   always_comb begin
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      if (advance) begin
         if (beat.last) begin
            sum_low_in  = '0;
            sum_high_in = '0;
         end else begin
            sum_low_in  = checksum[WORD_W-1:0];
            sum_high_in = checksum[SUM2_W-1:WORD_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_low_ff  <= '0;
         sum_high_ff <= '0;
      end else begin
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
      end
   end

endmodule

@@ rtl/fletcher64_checksum_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fletcher64_checksum_unit
// Streaming fletcher-64 checksum over beats of up to four bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat of message bytes (first byte in bits 7:0), the byte
//   count and a last flag. A beat is taken when req_valid is high and
//   req_stall is low. Only the last beat of a message produces a response.
//   rsp_checksum carries the second sum in bits 63:32 and the first in 31:0,
//   offered on rsp_valid and taken when rsp_stall is low.
// Timing:
//   one beat per cycle while req_stall is low. A beat is held in the input
//   register, where both modular sums are formed in a single pass; the
//   checksum of a last beat goes from there into the response register,
//   which drives rsp_valid and rsp_checksum.
// Reset:
//   synchronous; both sums clear and both registers empty.
// Stall:
//   while a checksum waits on rsp_stall, non-last beats keep flowing; a last
//   beat waits in the input register and req_stall rises until the response
//   register frees up.
// ----------------------------------------------------------------------------
module fletcher64_checksum_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [f64_pkg::WORD_W-1:0]        req_data_bytes,
   input  logic [f64_pkg::COUNT_W-1:0]       req_valid_bytes,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [f64_pkg::SUM2_W-1:0]        rsp_checksum
);
   import f64_pkg::*;

   logic              beat_valid_ff;
   logic              beat_valid_in;
   beat_type          beat_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SUM2_W-1:0] rsp_checksum_ff;
   logic [SUM2_W-1:0] checksum_next;
   logic              rsp_free;
   logic              advance;
   logic              req_take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // a non-last beat never needs the response register
   assign advance   = beat_valid_ff && (!beat_ff.last || rsp_free);
   assign req_stall = beat_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   f64_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .beat     (beat_ff),
      .checksum (checksum_next)
   );

   always_comb begin
      beat_valid_in = beat_valid_ff;
      if (req_take) begin
         beat_valid_in = 1'b1;
      end else if (advance) begin
         beat_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && beat_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         beat_valid_ff <= beat_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         beat_ff.data  <= req_data_bytes;
         beat_ff.count <= req_valid_bytes;
         beat_ff.last  <= req_last;
      end
      if (advance && beat_ff.last) begin
         rsp_checksum_ff <= checksum_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

endmodule
